// ===== hdl/mofc_pkg.sv =====
// types and constants for the mixer output filter and pcm conversion block
package mofc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int MAG_W    = 25;
  localparam int CMP_W    = (SUM_W > MAG_W) ? SUM_W : MAG_W;
  localparam int QUO_W    = 24;
  localparam int PCM_W    = 16;

  // magnitude limits that already saturate every output format
  localparam logic [MAG_W-1:0] LIM_PLAIN = MAG_W'(2 ** 23);
  localparam logic [MAG_W-1:0] LIM_DIV3  = MAG_W'(3 * (2 ** 23));

  // floor(a / 3) = (a * DIV3_MUL) >> DIV3_SHIFT for a below 2**25
  localparam int               DIV3_SHIFT = 26;
  localparam logic [MAG_W-1:0] DIV3_MUL   = MAG_W'(((2 ** 26) + 2) / 3);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_ON     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT = 2'd2;

  localparam logic [1:0] FILT_LIGHT  = 2'd1;
  localparam logic [1:0] FILT_STRONG = 2'd2;

  localparam logic FMT_S16 = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] out_left;
    logic signed [PCM_W-1:0] out_right;
  } out_word_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             div3;
  } lane_t;

endpackage

// ===== hdl/mix_output_filter_convert.sv =====
// mixer output stage: smoothing filter and pcm conversion, two-stage pipeline
// a word accepted goes into the stage-one register, then into the output register behind out_valid
// throughput: one word per cycle; only a stalled output register holds the pipe
// the whole pipe advances together when the output register is empty or taken
// reset (synchronous, active low): histories zero, filter off, stereo, 16-bit
// output, pipeline empty
module mix_output_filter_convert
  import mofc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [1:0] filter_mode_r;
  logic       stereo_on_r;
  logic       output_format_r;

  // per-channel history: one holds x[n-1], two holds x[n-2]
  logic signed [SAMPLE_W-1:0] left_hist_one_r, left_hist_one_nxt;
  logic signed [SAMPLE_W-1:0] left_hist_two_r, left_hist_two_nxt;
  logic signed [SAMPLE_W-1:0] right_hist_one_r, right_hist_one_nxt;
  logic signed [SAMPLE_W-1:0] right_hist_two_r, right_hist_two_nxt;

  // stage one: signed magnitude ahead of the divide
  logic  s1_valid_r;
  lane_t s1_left_r, s1_left_nxt;
  lane_t s1_right_r, s1_right_nxt;

  // output register
  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  logic advance;
  logic in_accept;
  logic filtering;

  // weighted sum, then magnitude clamped where every format already saturates
  function automatic lane_t lane_prep(input logic signed [SAMPLE_W-1:0] x,
                                      input logic signed [SAMPLE_W-1:0] h1,
                                      input logic signed [SAMPLE_W-1:0] h2,
                                      input logic [1:0]                 mode);
    logic signed [SUM_W-1:0] xe;
    logic signed [SUM_W-1:0] h1e;
    logic signed [SUM_W-1:0] h2e;
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-1:0]        a;
    logic [CMP_W-1:0]        av;
    logic [MAG_W-1:0]        lim;
    lane_t                   r;
    xe     = SUM_W'(x);
    h1e    = SUM_W'(h1);
    h2e    = SUM_W'(h2);
    r.div3 = 1'b0;
    lim    = LIM_PLAIN;
    case (mode)
      FILT_LIGHT: begin
        s      = h1e + (xe <<< 1);
        r.div3 = 1'b1;
        lim    = LIM_DIV3;
      end
      FILT_STRONG: s = h2e + h1e + (h1e <<< 1) + (xe <<< 2);
      default:     s = xe;
    endcase
    r.neg = s[SUM_W-1];
    a = r.neg ? $unsigned(-s) : $unsigned(s);
    // divide by eight toward zero on the magnitude
    if (mode == FILT_STRONG) a = a >> 3;
    av = CMP_W'(a);
    r.mag = (av > CMP_W'(lim)) ? lim : MAG_W'(av);
    return r;
  endfunction

  // divide by three when flagged, drop fraction bits, saturate, pick the format
  function automatic logic [PCM_W-1:0] lane_pcm(input lane_t l, input logic fmt);
    logic [2*MAG_W-1:0] p;
    logic [QUO_W-1:0]   q;
    logic [PCM_W-1:0]   nm;
    logic [PCM_W-1:0]   n16;
    p   = {{MAG_W{1'b0}}, l.mag} * {{MAG_W{1'b0}}, DIV3_MUL};
    q   = l.div3 ? p[DIV3_SHIFT +: QUO_W] : l.mag[QUO_W-1:0];
    nm  = q[QUO_W-1:8];
    if (l.neg) n16 = -nm;
    else       n16 = nm[PCM_W-1] ? {1'b0, {(PCM_W-1){1'b1}}} : nm;
    if (fmt == FMT_S16) return n16;
    // floor shift by eight is already inside -128..127, then offset binary
    return {8'h00, ~n16[PCM_W-1], n16[PCM_W-2:8]};
  endfunction

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign in_accept = in_valid && advance;
  assign filtering = (filter_mode_r == FILT_LIGHT) || (filter_mode_r == FILT_STRONG);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_left_nxt  = lane_prep(in_data.in_left, left_hist_one_r, left_hist_two_r,
                             filter_mode_r);
    s1_right_nxt = lane_prep(in_data.in_right, right_hist_one_r, right_hist_two_r,
                             filter_mode_r);

    left_hist_one_nxt  = left_hist_one_r;
    left_hist_two_nxt  = left_hist_two_r;
    right_hist_one_nxt = right_hist_one_r;
    right_hist_two_nxt = right_hist_two_r;
    // histories shift only while a filter is on; mono leaves the right side alone
    if (in_accept && filtering) begin
      left_hist_two_nxt = left_hist_one_r;
      left_hist_one_nxt = in_data.in_left;
      if (stereo_on_r) begin
        right_hist_two_nxt = right_hist_one_r;
        right_hist_one_nxt = in_data.in_right;
      end
    end

    out_data_nxt.out_left  = lane_pcm(s1_left_r, output_format_r);
    out_data_nxt.out_right = stereo_on_r ? lane_pcm(s1_right_r, output_format_r)
                                         : '0;
  end

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r   <= 2'd0;
      stereo_on_r     <= 1'b1;
      output_format_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_MODE:   filter_mode_r   <= cfg_data[1:0];
        CFG_STEREO_ON:     stereo_on_r     <= cfg_data[0];
        CFG_OUTPUT_FORMAT: output_format_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_hist_one_r  <= '0;
      left_hist_two_r  <= '0;
      right_hist_one_r <= '0;
      right_hist_two_r <= '0;
    end else begin
      left_hist_one_r  <= left_hist_one_nxt;
      left_hist_two_r  <= left_hist_two_nxt;
      right_hist_one_r <= right_hist_one_nxt;
      right_hist_two_r <= right_hist_two_nxt;
    end
  end

  // pipeline control: both stages move together on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_left_r  <= s1_left_nxt;
      s1_right_r <= s1_right_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // a word in stage one is never dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("stage one word lost during stall");

  // histories move only on an accepted word with a filter on
  a_hist_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && filtering) |=> $stable(left_hist_one_r) && $stable(left_hist_two_r)
                                  && $stable(right_hist_one_r) && $stable(right_hist_two_r))
    else $error("history changed without a filtered word");

  // mono words carry a zero right sample
  a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !stereo_on_r |-> out_data_r.out_right == '0)
    else $error("right sample not zero in mono");

  // 8-bit format keeps the upper byte clear
  a_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (output_format_r != FMT_S16) |->
      out_data_r.out_left[PCM_W-1:8] == '0 && out_data_r.out_right[PCM_W-1:8] == '0)
    else $error("8-bit sample out of range");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the mixer output smoothing filter and pcm conversion stage
`timescale 1ns / 1ps

module testbench
  import mofc_pkg::*;
();

  // register values the package does not name
  localparam logic [1:0]           FILT_NONE  = 2'd0;
  localparam logic [1:0]           FILT_UNDEF = 2'd3;
  localparam logic                 FMT_U8     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // fixed point and pcm limits
  localparam longint FRAC_SCALE = 256;
  localparam longint PCM_MIN    = -32768;
  localparam longint PCM_MAX    = 32767;
  localparam longint BYTE_MIN   = -128;
  localparam longint BYTE_MAX   = 127;
  localparam longint BYTE_BIAS  = 128;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_LIMIT = 8;
  localparam int PHASES       = 19;
  localparam int PHASE_WORDS  = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mix_output_filter_convert i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the block: registers at their reset values, histories zero
  logic [1:0]                 cur_mode   = FILT_NONE;
  logic                       cur_stereo = 1'b1;
  logic                       cur_fmt    = FMT_S16;
  logic signed [SAMPLE_W-1:0] left_h1 = '0;
  logic signed [SAMPLE_W-1:0] left_h2 = '0;
  logic signed [SAMPLE_W-1:0] right_h1 = '0;
  logic signed [SAMPLE_W-1:0] right_h2 = '0;

  // pcm words still owed by the block, oldest first
  out_word_t pcm_q[$];

  int  fails = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count, pcm_q.size());
      $display("** mix_output_filter_convert: FAILED **");
      $finish;
    end
  end

  // idle cycles before the next word or the next ready; calm stretches draw none
  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  // weighted smoothing with truncation toward zero, modes 0 and 3 pass through
  function automatic longint smooth_sample(longint x, longint h1, longint h2,
                                           logic [1:0] mode);
    case (mode)
      FILT_LIGHT:  return (h1 + 2 * x) / 3;
      FILT_STRONG: return (h2 + 3 * h1 + 4 * x) / 8;
      default:     return x;
    endcase
  endfunction

  // drop the fraction (toward zero), then saturate, or floor, clamp and rebias to 8-bit offset binary
  function automatic logic [PCM_W-1:0] pcm_of(longint y, logic fmt);
    longint n;
    n = y / FRAC_SCALE;
    if (fmt == FMT_S16) begin
      if (n < PCM_MIN) n = PCM_MIN;
      else if (n > PCM_MAX) n = PCM_MAX;
    end else begin
      n = n >>> 8;  // floor
      if (n < BYTE_MIN) n = BYTE_MIN;
      else if (n > BYTE_MAX) n = BYTE_MAX;
      n = n + BYTE_BIAS;
    end
    return n[PCM_W-1:0];
  endfunction

  function automatic in_word_t make_word(logic signed [SAMPLE_W-1:0] l,
                                         logic signed [SAMPLE_W-1:0] r);
    in_word_t w;
    w.in_left  = l;
    w.in_right = r;
    return w;
  endfunction

  // same from plain integer samples, cut to the sample width
  function automatic in_word_t int_word(int l, int r);
    return make_word(l[SAMPLE_W-1:0], r[SAMPLE_W-1:0]);
  endfunction

  // random sample biased toward zero, the rails and the 8-bit step edges
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(0, 5))
      1: v = int'($urandom_range(0, 2047)) - 1024;
      2: v = int'(SAMPLE_MAX) - int'($urandom_range(0, 512));
      3: v = int'(SAMPLE_MIN) + int'($urandom_range(0, 512));
      4: v = (int'($urandom_range(0, 255)) - 128) * 65536 + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // work out the pcm word for an accepted mixed word and advance the histories
  task automatic predict_word(input in_word_t w);
    out_word_t r;
    longint    y;
    bit        shift_hist;
    shift_hist = (cur_mode == FILT_LIGHT) || (cur_mode == FILT_STRONG);
    y = smooth_sample(longint'(w.in_left), longint'(left_h1), longint'(left_h2), cur_mode);
    r.out_left = pcm_of(y, cur_fmt);
    if (shift_hist) begin
      left_h2 = left_h1;
      left_h1 = w.in_left;
    end
    // mono leaves the right path and its histories alone
    if (cur_stereo) begin
      y = smooth_sample(longint'(w.in_right), longint'(right_h1), longint'(right_h2),
                        cur_mode);
      r.out_right = pcm_of(y, cur_fmt);
      if (shift_hist) begin
        right_h2 = right_h1;
        right_h1 = w.in_right;
      end
    end else begin
      r.out_right = '0;
    end
    pcm_q.push_back(r);
  endtask

  // offer one word after a random gap; valid stays up until the block takes it
  task automatic send_word(input in_word_t w);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
    words_sent++;
  endtask

  // stop sending and wait until every owed word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pcm_q.size() != 0) @(posedge clk);
  endtask

  // write all registers plus the unused index, one per clock, with the pipe empty
  task automatic write_config(input logic [CFG_DATA_W-1:0] mode_val,
                              input logic [CFG_DATA_W-1:0] stereo_val,
                              input logic [CFG_DATA_W-1:0] fmt_val);
    logic [CFG_IDX_W-1:0]  order [4];
    logic [CFG_DATA_W-1:0] vals  [4];
    wait_drained();
    order[0] = CFG_FILTER_MODE;   vals[0] = mode_val;
    order[1] = CFG_STEREO_ON;     vals[1] = stereo_val;
    order[2] = CFG_OUTPUT_FORMAT; vals[2] = fmt_val;
    order[3] = CFG_SPARE;         vals[3] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (order[i])
        CFG_FILTER_MODE:   cur_mode   = vals[i];
        CFG_STEREO_ON:     cur_stereo = vals[i][0];
        CFG_OUTPUT_FORMAT: cur_fmt    = vals[i][0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  // result side: check each taken word, then draw how long ready stays low
  always @(posedge clk) begin : pcm_side
    out_word_t want;
    int        rx_wait;
    if (!rst_n) begin
      rx_wait   = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pcm_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected word left=%0d right=%0d", out_data.out_left,
                     out_data.out_right);
        end else begin
          want = pcm_q.pop_front();
          if (out_data.out_left !== want.out_left || out_data.out_right !== want.out_right) begin
            fails++;
            if (fails <= 10)
              $display("mismatch on word %0d: left exp %0d got %0d, right exp %0d got %0d",
                       words_checked, want.out_left, out_data.out_left,
                       want.out_right, out_data.out_right);
          end
        end
        words_checked++;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = draw_gap(rx_calm);
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // reset defaults: no filter, stereo, 16-bit; rails and truncation of small negatives
  task automatic test_plain_extremes();
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MAX));
    send_word(int_word(0, -1));
    send_word(int_word(-255, -256));
    send_word(int_word(32767 * 256, -32767 * 256));
    send_word(int_word(255, 256));
  endtask

  // 8-bit offset binary: clamps at both ends and floor on negatives
  task automatic test_byte_format();
    write_config(FILT_NONE, 2'b11, 2'b10);
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(int_word(-256, 65535));
    send_word(int_word(65536, -65536));
    send_word(int_word(-65537, -65792));
  endtask

  // light smoothing from zero histories, full swings, division by three near zero
  task automatic test_light_filter();
    write_config(FILT_LIGHT, 2'b01, {1'b0, FMT_S16});
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MAX));
    send_word(int_word(-1, 1));
    send_word(int_word(0, 0));
  endtask

  // strong smoothing in 8-bit format
  task automatic test_strong_filter();
    write_config(FILT_STRONG, 2'b01, {1'b0, FMT_U8});
    send_word(make_word(SAMPLE_MIN, SAMPLE_MAX));
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(int_word(-3, 5));
  endtask

  // mono must zero the right output and keep its histories for later
  task automatic test_mono_path();
    write_config(FILT_STRONG, 2'b10, {1'b0, FMT_S16});
    send_word(make_word(SAMPLE_MAX, random_sample()));
    send_word(make_word(SAMPLE_MIN, random_sample()));
    write_config(FILT_LIGHT, 2'b01, {1'b0, FMT_S16});
    send_word(int_word(0, 0));
  endtask

  // filter mode 3 passes through and freezes histories
  task automatic test_undefined_mode();
    write_config(FILT_UNDEF, 2'b01, {1'b0, FMT_S16});
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN));
    send_word(int_word(-12345, 12345));
    write_config(FILT_LIGHT, 2'b01, {1'b0, FMT_S16});
    send_word(int_word(0, 0));
  endtask

  // random phases, each under a fresh register setting, some with a full drain inside
  task automatic test_random_traffic();
    int pause_at;
    for (int p = 0; p < PHASES; p++) begin
      write_config(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                   CFG_DATA_W'($urandom_range(0, 3)));
      tx_calm  = ($urandom_range(0, 3) == 0);
      pause_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, PHASE_WORDS - 1)) : -1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // hold the sender until the pipe and the output are empty
        if (k == pause_at) wait_drained();
        send_word(make_word(random_sample(), random_sample()));
      end
    end
    tx_calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_extremes();
    test_byte_format();
    test_light_filter();
    test_strong_filter();
    test_mono_path();
    test_undefined_mode();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_LIMIT) @(posedge clk);

    $display("sent %0d mixed words over %0d register writes, checked %0d pcm words",
             words_sent, reg_writes, words_checked);
    $display("filter modes 0..3, stereo and mono, 8- and 16-bit output; %0d mismatches",
             fails);
    if (fails == 0) begin
      $display("** mix_output_filter_convert: PASSED **");
    end else begin
      $display("** mix_output_filter_convert: FAILED **");
    end
    $finish;
  end

endmodule
